/* rtl/cidfp_pkg.sv */
`timescale 1ns / 1ps
// Package for the checked identifier frame parser.
// Holds frame layout constants, status codes, shared structs and the FNV-1a step.
// No dependencies.

package cidfp_pkg;

	localparam int unsigned PAYLOAD_BYTES = 16;

	// frame layout as byte offsets
	localparam logic [5:0] MAGIC_LEN = 6'd8;
	localparam logic [5:0] VER_END   = 6'd10;
	localparam logic [5:0] HDR_END   = 6'd18;
	localparam logic [5:0] HIGH_END  = 6'd26;
	localparam logic [5:0] PAY_END   = 6'd34;
	localparam logic [5:0] FRAME_LEN = 6'd42;
	localparam logic [5:0] COUNT_SAT = 6'd43;

	localparam logic [63:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] PAYLOAD_LEN = 64'(PAYLOAD_BYTES);

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TRUNCATED    = 3'd1,
		ST_BAD_MAGIC    = 3'd2,
		ST_BAD_VERSION  = 3'd3,
		ST_INVALID      = 3'd4,
		ST_SUM_MISMATCH = 3'd5
	} status_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} step_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] id_high;
		logic [63:0] id_low;
	} result_t;

	// magic "TPQCAMPI"
	function automatic logic [7:0] magic_byte(input logic [2:0] idx);
		logic [7:0] m;
		unique case (idx)
			3'd0: m = 8'h54;
			3'd1: m = 8'h50;
			3'd2: m = 8'h51;
			3'd3: m = 8'h43;
			3'd4: m = 8'h41;
			3'd5: m = 8'h4D;
			3'd6: m = 8'h50;
			3'd7: m = 8'h49;
			default: m = 8'h00;
		endcase
		return m;
	endfunction

	// one FNV-1a step; prime 0x100000001B3 as shifts and adds
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

/* rtl/cidfp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the frame byte input and the result output.
// No dependencies.

interface cidfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface cidfp_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] id_high;
	logic [63:0] id_low;

	modport source (output valid, output status, output id_high, output id_low, input ready);
	modport sink (input valid, input status, input id_high, input id_low, output ready);
endinterface

/* rtl/cidfp_frame.sv */
`timescale 1ns / 1ps
// Frame state: byte count, magic check, header fields, running hash, identifier.
// Decodes the status for a final byte. Depends on cidfp_pkg.

module cidfp_frame (
	input  logic                clk,
	input  logic                arst_n,
	input  cidfp_pkg::step_t    step,
	input  logic [15:0]         expected_version,
	output cidfp_pkg::result_t  result
);

	logic [5:0]  count_q, count_d;
	logic        magic_bad_q, magic_bad_d;
	logic [15:0] version_q, version_d;
	logic [63:0] length_q, length_d;
	logic [63:0] hash_q, hash_d;
	logic [63:0] high_q, high_d;
	logic [63:0] low_q, low_d;
	logic [63:0] sum_q, sum_d;
	cidfp_pkg::status_t st;

	always_comb begin
		magic_bad_d = magic_bad_q;
		version_d   = version_q;
		length_d    = length_q;
		hash_d      = hash_q;
		high_d      = high_q;
		low_d       = low_q;
		sum_d       = sum_q;
		if (count_q < cidfp_pkg::MAGIC_LEN) begin
			if (step.data != cidfp_pkg::magic_byte(count_q[2:0]))
				magic_bad_d = 1'b1;
		end else if (count_q < cidfp_pkg::VER_END) begin
			version_d = {step.data, version_q[15:8]};
		end else if (count_q < cidfp_pkg::HDR_END) begin
			length_d = {step.data, length_q[63:8]};
		end else if (count_q < cidfp_pkg::PAY_END) begin
			hash_d = cidfp_pkg::fnv_step(hash_q, step.data);
			if (count_q < cidfp_pkg::HIGH_END)
				high_d = {step.data, high_q[63:8]};
			else
				low_d = {step.data, low_q[63:8]};
		end else if (count_q < cidfp_pkg::FRAME_LEN) begin
			sum_d = {step.data, sum_q[63:8]};
		end
		count_d = (count_q < cidfp_pkg::COUNT_SAT) ? count_q + 6'd1 : cidfp_pkg::COUNT_SAT;
	end

	// hash is complete before the checksum bytes, so the held value is compared
	always_comb begin
		if (count_d < cidfp_pkg::MAGIC_LEN)
			st = cidfp_pkg::ST_TRUNCATED;
		else if (magic_bad_d)
			st = cidfp_pkg::ST_BAD_MAGIC;
		else if (count_d < cidfp_pkg::HDR_END)
			st = cidfp_pkg::ST_TRUNCATED;
		else if (version_d != expected_version)
			st = cidfp_pkg::ST_BAD_VERSION;
		else if (length_d != cidfp_pkg::PAYLOAD_LEN)
			st = cidfp_pkg::ST_INVALID;
		else if (count_d < cidfp_pkg::FRAME_LEN)
			st = cidfp_pkg::ST_TRUNCATED;
		else if (count_d > cidfp_pkg::FRAME_LEN)
			st = cidfp_pkg::ST_INVALID;
		else if (sum_d != hash_q)
			st = cidfp_pkg::ST_SUM_MISMATCH;
		else if (high_d == 64'd0 && low_d == 64'd0)
			st = cidfp_pkg::ST_INVALID;
		else
			st = cidfp_pkg::ST_OK;
		result.status  = st;
		result.id_high = (st == cidfp_pkg::ST_OK) ? high_d : 64'd0;
		result.id_low  = (st == cidfp_pkg::ST_OK) ? low_d : 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= 6'd0;
			magic_bad_q <= 1'b0;
			version_q   <= 16'd0;
			length_q    <= 64'd0;
			hash_q      <= cidfp_pkg::FNV_BASIS;
			high_q      <= 64'd0;
			low_q       <= 64'd0;
			sum_q       <= 64'd0;
		end else if (step.valid) begin
			if (step.last) begin
				count_q     <= 6'd0;
				magic_bad_q <= 1'b0;
				version_q   <= 16'd0;
				length_q    <= 64'd0;
				hash_q      <= cidfp_pkg::FNV_BASIS;
				high_q      <= 64'd0;
				low_q       <= 64'd0;
				sum_q       <= 64'd0;
			end else begin
				count_q     <= count_d;
				magic_bad_q <= magic_bad_d;
				version_q   <= version_d;
				length_q    <= length_d;
				hash_q      <= hash_d;
				high_q      <= high_d;
				low_q       <= low_d;
				sum_q       <= sum_d;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cidfp_pkg::COUNT_SAT)
		else $error("byte count past saturation");

	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		step.valid && step.last |=> count_q == 6'd0 && !magic_bad_q
			&& hash_q == cidfp_pkg::FNV_BASIS)
		else $error("frame state not cleared after final byte");

	a_magic_needs_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		magic_bad_q |-> count_q != 6'd0)
		else $error("magic flag set with empty frame");

endmodule

/* rtl/cidfp_result_reg.sv */
`timescale 1ns / 1ps
// Result register driving the result channel; holds a request until taken.
// Depends on cidfp_pkg and cidfp_if.

module cidfp_result_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  cidfp_pkg::result_t data,
	output logic               busy,
	cidfp_result_if.source     result
);

	logic               valid_q;
	cidfp_pkg::result_t data_q;

	assign busy = valid_q && !result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (result.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= data;
	end

	assign result.valid   = valid_q;
	assign result.status  = data_q.status;
	assign result.id_high = data_q.id_high;
	assign result.id_low  = data_q.id_low;

endmodule

/* rtl/checked_id_frame_parser_unit.sv */
`timescale 1ns / 1ps
// Checked identifier frame parser, top level.
// Usage:
//   frame_bytes carries one frame byte per request, with last on the final byte.
//   A frame is magic "TPQCAMPI", a 16-bit version, a 64-bit length of 16, a
//   16-byte payload holding the identifier halves and a 64-bit FNV-1a checksum,
//   all little-endian. result carries one request per frame: status plus the
//   identifier halves, which are zero unless status is ok.
//   cfg_we/cfg_data write the expected version (reset value 1); write it only
//   while no frame is in flight.
// Throughput: one byte per cycle, set by the single input stage feeding the
//   frame state update and status decode; a final byte waits on a pending result.
// Result path: a final byte is held in the input stage, then its result is registered.
// Reset: arst_n clears the frame state, the input stage and the result valid.
// Stall: while a result waits, mid-frame bytes keep flowing; a final byte
//   holds in the input stage until the result register frees, and the input
//   then backs up.
// Depends on cidfp_pkg, cidfp_if, cidfp_frame and cidfp_result_reg.

module checked_id_frame_parser_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [15:0]      cfg_data,
	cidfp_byte_if.sink       frame_bytes,
	cidfp_result_if.source   result
);

	logic               valid_s1;
	logic               last_s1;
	logic [7:0]         data_s1;
	logic [15:0]        exp_version_q;
	logic               out_busy;
	logic               advance;
	logic               load;
	cidfp_pkg::step_t   step;
	cidfp_pkg::result_t frame_result;

	assign advance           = valid_s1 && (!last_s1 || !out_busy);
	assign load              = advance && last_s1;
	assign frame_bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			exp_version_q <= 16'd1;
		else if (cfg_we)
			exp_version_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (frame_bytes.ready)
			valid_s1 <= frame_bytes.valid;
	end

	always_ff @(posedge clk) begin
		if (frame_bytes.ready && frame_bytes.valid) begin
			data_s1 <= frame_bytes.data_byte;
			last_s1 <= frame_bytes.last;
		end
	end

	always_comb begin
		step.valid = advance;
		step.last  = last_s1;
		step.data  = data_s1;
	end

	cidfp_frame u_frame (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (step),
		.expected_version (exp_version_q),
		.result           (frame_result)
	);

	cidfp_result_reg u_result_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.data   (frame_result),
		.busy   (out_busy),
		.result (result)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !out_busy)
		else $error("result overwritten while waiting");

	a_final_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && out_busy |=> valid_s1 && last_s1 && $stable(data_s1))
		else $error("stalled final byte lost");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> result.valid)
		else $error("loaded result not presented");

endmodule
